// ===== rtl/core/mjd2y_pkg.sv =====
package mjd2y_pkg;

  // Field widths
  localparam int unsigned DAY_BITS  = 17;
  localparam int unsigned FRAC_BITS = 32;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned MDAY_W    = 5;
  localparam int unsigned YDAY_W    = 9;
  localparam int unsigned YFRAC_W   = 33;

  // Pipeline depth, start to done
  localparam int unsigned PIPE_LAT  = 7;
  localparam int unsigned GREG_LAT  = PIPE_LAT;
  localparam int unsigned ALGN_LAT  = 3;
  localparam int unsigned YF_LAT    = PIPE_LAT - ALGN_LAT;

  localparam longint unsigned MJD_MAX = (64'd1 << DAY_BITS) - 64'd1;

  // Gregorian date: alpha = (4*jdn - 7468865) / 146097
  localparam longint unsigned JDN_OFS   = 64'd2400001;
  localparam longint unsigned JDN_MAX   = MJD_MAX + JDN_OFS;
  localparam int unsigned     JDN_W     = $clog2(JDN_MAX + 64'd1);
  localparam longint unsigned ALPHA_OFS = 64'd7468865;
  localparam longint unsigned ALPHA_DIV = 64'd146097;
  localparam longint unsigned XA_MAX    = 64'd4 * JDN_MAX - ALPHA_OFS;
  localparam int unsigned     XA_W      = $clog2(XA_MAX + 64'd1);
  localparam int unsigned     SA        = XA_W + $clog2(ALPHA_DIV);
  localparam longint unsigned MA        = ((64'd1 << SA) + ALPHA_DIV - 64'd1) / ALPHA_DIV;
  localparam int unsigned     MA_W      = $clog2(MA + 64'd1);
  localparam longint unsigned ALPHA_MAX = XA_MAX / ALPHA_DIV;
  localparam int unsigned     ALPHA_W   = $clog2(ALPHA_MAX + 64'd1);

  // c = jdn + 1 + alpha - alpha/4 + 1524
  localparam longint unsigned JDN_TO_C  = 64'd1525;
  localparam longint unsigned C_MAX     = JDN_MAX + ALPHA_MAX + JDN_TO_C;
  localparam int unsigned     C_W       = $clog2(C_MAX + 64'd1);

  // d = (20*c - 2442) / 7305
  localparam longint unsigned XD_OFS    = 64'd2442;
  localparam longint unsigned D_DIV     = 64'd7305;
  localparam longint unsigned XD_MAX    = 64'd20 * C_MAX - XD_OFS;
  localparam int unsigned     XD_W      = $clog2(XD_MAX + 64'd1);
  localparam int unsigned     SD        = XD_W + $clog2(D_DIV);
  localparam longint unsigned MD        = ((64'd1 << SD) + D_DIV - 64'd1) / D_DIV;
  localparam int unsigned     MD_W      = $clog2(MD + 64'd1);
  localparam longint unsigned D_MAX     = XD_MAX / D_DIV;
  localparam int unsigned     D_W       = $clog2(D_MAX + 64'd1);

  // g = 10000*(c - e) / 306001, c - e below 512
  localparam int unsigned     CE_W      = 9;
  localparam longint unsigned G_MUL     = 64'd10000;
  localparam longint unsigned G_DIV     = 64'd306001;
  localparam int unsigned     SG        = CE_W + $clog2(G_DIV);
  localparam longint unsigned KG        = ((G_MUL << SG) + G_DIV - 64'd1) / G_DIV;
  localparam int unsigned     KG_W      = $clog2(KG + 64'd1);
  localparam int unsigned     G_W       = 4;

  localparam longint unsigned YEAR_BASE = 64'd4716;

  // Four-year cycle of the aligned calendar
  localparam longint unsigned YEAR_DIV  = 64'd1461;
  localparam int unsigned     REM_W     = $clog2(YEAR_DIV);

  // Aligned calendar: day count minus one = mjd + 2401415
  localparam longint unsigned JM1_OFS   = 64'd2401415;
  localparam longint unsigned JM1_MAX   = MJD_MAX + JM1_OFS;
  localparam int unsigned     JM1_W     = $clog2(JM1_MAX + 64'd1);
  localparam int unsigned     SQ        = JM1_W + REM_W;
  localparam longint unsigned MQ        = ((64'd1 << SQ) + YEAR_DIV - 64'd1) / YEAR_DIV;
  localparam int unsigned     MQ_W      = $clog2(MQ + 64'd1);
  localparam longint unsigned QUAD_MAX  = JM1_MAX / YEAR_DIV;
  localparam int unsigned     QUAD_W    = $clog2(QUAD_MAX + 64'd1);

  // Year fraction: floor(((nd << 34) + fs) / 1461), two long-division digits
  localparam int unsigned     FS_W      = 34;
  localparam int unsigned     FS_UP     = (FRAC_BITS <= FS_W) ? FS_W - FRAC_BITS : 0;
  localparam int unsigned     FS_DN     = (FRAC_BITS > FS_W) ? FRAC_BITS - FS_W : 0;
  localparam int unsigned     FS_LO_W   = 17;
  localparam int unsigned     FS_HI_W   = FS_W - FS_LO_W;
  localparam int unsigned     X1F_W     = YDAY_W + FS_HI_W;
  localparam int unsigned     SF1       = X1F_W + REM_W;
  localparam longint unsigned MF1       = ((64'd1 << SF1) + YEAR_DIV - 64'd1) / YEAR_DIV;
  localparam int unsigned     MF1_W     = $clog2(MF1 + 64'd1);
  localparam int unsigned     Q1F_W     = YFRAC_W - FS_LO_W;
  localparam int unsigned     X2F_W     = REM_W + FS_LO_W;
  localparam int unsigned     SF2       = X2F_W + REM_W;
  localparam longint unsigned MF2       = ((64'd1 << SF2) + YEAR_DIV - 64'd1) / YEAR_DIV;
  localparam int unsigned     MF2_W     = $clog2(MF2 + 64'd1);

  typedef struct packed {
    logic [DAY_BITS-1:0]  mjd_day;
    logic [FRAC_BITS-1:0] mjd_frac;
  } mjd2y_in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  greg_year;
    logic [MONTH_W-1:0] greg_month;
    logic [MDAY_W-1:0]  greg_day;
    logic [YEAR_W-1:0]  aligned_year;
    logic [YDAY_W-1:0]  day_of_year;
    logic [YFRAC_W-1:0] year_fraction;
  } mjd2y_res_t;

endpackage

// ===== rtl/core/mjd2y_greg.sv =====
module mjd2y_greg
  import mjd2y_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [DAY_BITS-1:0] mday_i,
  output logic                valid_o,
  output logic [YEAR_W-1:0]   year_o,
  output logic [MONTH_W-1:0]  month_o,
  output logic [MDAY_W-1:0]   day_o
);

  localparam int unsigned PA_W = XA_W + MA_W;
  localparam int unsigned PD_W = XD_W + MD_W;
  localparam int unsigned PG_W = CE_W + KG_W;
  localparam int unsigned CX_W = C_W + 5;
  localparam int unsigned DE_W = D_W + 11;

  // floor(30.6001 * g)
  function automatic logic [CE_W-1:0] month_base(input logic [G_W-1:0] g);
    logic [CE_W-1:0] v;
    case (g)
      4'd0:    v = CE_W'(0);
      4'd1:    v = CE_W'(30);
      4'd2:    v = CE_W'(61);
      4'd3:    v = CE_W'(91);
      4'd4:    v = CE_W'(122);
      4'd5:    v = CE_W'(153);
      4'd6:    v = CE_W'(183);
      4'd7:    v = CE_W'(214);
      4'd8:    v = CE_W'(244);
      4'd9:    v = CE_W'(275);
      4'd10:   v = CE_W'(306);
      4'd11:   v = CE_W'(336);
      4'd12:   v = CE_W'(367);
      4'd13:   v = CE_W'(397);
      4'd14:   v = CE_W'(428);
      4'd15:   v = CE_W'(459);
      default: v = CE_W'(0);
    endcase
    return v;
  endfunction

  logic [GREG_LAT-1:0] vld_q;

  logic [JDN_W-1:0]   jdn_d, jdn_q;
  logic [JDN_W+1:0]   jdn4;
  logic [XA_W-1:0]    xa;
  logic [PA_W-1:0]    pa_d, pa_q;
  logic [ALPHA_W-1:0] alpha;
  logic [C_W-1:0]     c_d, c_q, c3_q, c4_q;
  logic [CX_W-1:0]    c20;
  logic [XD_W-1:0]    xd_d, xd_q;
  logic [PD_W-1:0]    pd_q;
  logic [D_W-1:0]     d5_d, d5_q, d6_q;
  logic [DE_W-1:0]    d1461;
  logic [C_W-1:0]     e;
  logic [CE_W-1:0]    ce_d, ce5_q, ce6_q;
  logic [PG_W-1:0]    pg_q;
  logic [G_W-1:0]     g;
  logic [MONTH_W-1:0] month_d, month_q;
  logic [MDAY_W-1:0]  day_d, day_q;
  logic [YEAR_W-1:0]  year_d, year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[GREG_LAT-2:0], valid_i};
    end
  end

  // s1: day count and alpha product
  always_comb begin
    jdn_d = JDN_W'(mday_i) + JDN_W'(JDN_OFS);
    jdn4  = {jdn_d, 2'b00};
    xa    = XA_W'(jdn4 - (JDN_W+2)'(ALPHA_OFS));
    pa_d  = PA_W'(xa) * PA_W'(MA);
  end

  // s2: century correction
  always_comb begin
    alpha = pa_q[SA +: ALPHA_W];
    c_d   = C_W'(jdn_q) + C_W'(alpha) - C_W'(alpha >> 2) + C_W'(JDN_TO_C);
  end

  // s3: 20c - 2442
  always_comb begin
    c20  = CX_W'({c_q, 4'b0000}) + CX_W'({c_q, 2'b00});
    xd_d = XD_W'(c20 - CX_W'(XD_OFS));
  end

  // s5: year count d and day in March-based year
  always_comb begin
    d5_d  = pd_q[SD +: D_W];
    d1461 = DE_W'(d5_d) * DE_W'(YEAR_DIV);
    e     = C_W'(d1461 >> 2);
    ce_d  = CE_W'(c4_q - e);
  end

  // s7: month index g, then calendar fields
  always_comb begin
    g       = pg_q[SG +: G_W];
    day_d   = MDAY_W'(ce6_q - month_base(g));
    month_d = (g < G_W'(14)) ? MONTH_W'(g - G_W'(1)) : MONTH_W'(g - G_W'(13));
    year_d  = YEAR_W'(d6_q - ((month_d > MONTH_W'(2)) ? D_W'(YEAR_BASE)
                                                       : D_W'(YEAR_BASE - 64'd1)));
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      jdn_q <= jdn_d;
      pa_q  <= pa_d;
    end
    if (vld_q[0]) begin
      c_q <= c_d;
    end
    if (vld_q[1]) begin
      xd_q <= xd_d;
      c3_q <= c_q;
    end
    if (vld_q[2]) begin
      pd_q <= PD_W'(xd_q) * PD_W'(MD);
      c4_q <= c3_q;
    end
    if (vld_q[3]) begin
      d5_q  <= d5_d;
      ce5_q <= ce_d;
    end
    if (vld_q[4]) begin
      pg_q  <= PG_W'(ce5_q) * PG_W'(KG);
      d6_q  <= d5_q;
      ce6_q <= ce5_q;
    end
    if (vld_q[5]) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  assign valid_o = vld_q[GREG_LAT-1];
  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

// ===== rtl/core/mjd2y_yfrac.sv =====
module mjd2y_yfrac
  import mjd2y_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [YDAY_W-1:0]    nd_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic                 valid_o,
  output logic [YFRAC_W-1:0]   yf_o
);

  localparam int unsigned FSX_W = FRAC_BITS + FS_W;
  localparam int unsigned P1_W  = X1F_W + MF1_W;
  localparam int unsigned P2_W  = X2F_W + MF2_W;
  localparam int unsigned Q1M_W = Q1F_W + REM_W;

  logic [YF_LAT-1:0]  vld_q;
  logic [FSX_W-1:0]   fsx;
  logic [FS_W-1:0]    fs;
  logic [X1F_W-1:0]   x1, x1_q;
  logic [P1_W-1:0]    p1_q;
  logic [FS_LO_W-1:0] lo1_q, lo2_q;
  logic [Q1F_W-1:0]   q1, q1_q, q1_3_q;
  logic [Q1M_W-1:0]   q1m;
  logic [REM_W-1:0]   r1, r1_q;
  logic [X2F_W-1:0]   x2;
  logic [P2_W-1:0]    p2_q;
  logic [FS_LO_W-1:0] q2;
  logic [YFRAC_W-1:0] yf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[YF_LAT-2:0], valid_i};
    end
  end

  // Fraction rescaled to 34 bits; high digit first
  always_comb begin
    fsx = (FSX_W'(frac_i) << FS_UP) >> FS_DN;
    fs  = fsx[FS_W-1:0];
    x1  = {nd_i, fs[FS_W-1 -: FS_HI_W]};
  end

  always_comb begin
    q1  = p1_q[SF1 +: Q1F_W];
    q1m = Q1M_W'(q1) * Q1M_W'(YEAR_DIV);
    r1  = REM_W'(x1_q - X1F_W'(q1m));
  end

  assign x2 = {r1_q, lo2_q};
  assign q2 = p2_q[SF2 +: FS_LO_W];

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p1_q  <= P1_W'(x1) * P1_W'(MF1);
      x1_q  <= x1;
      lo1_q <= fs[FS_LO_W-1:0];
    end
    if (vld_q[0]) begin
      q1_q  <= q1;
      r1_q  <= r1;
      lo2_q <= lo1_q;
    end
    if (vld_q[1]) begin
      p2_q   <= P2_W'(x2) * P2_W'(MF2);
      q1_3_q <= q1_q;
    end
    if (vld_q[2]) begin
      yf_q <= {q1_3_q, q2};
    end
  end

  assign valid_o = vld_q[YF_LAT-1];
  assign yf_o    = yf_q;

endmodule

// ===== rtl/core/mjd_to_decimal_year_core.sv =====
// MJD to calendar date and decimal year. One beat in per clock: a beat is
// taken on every edge with start high, busy never rises. Each beat comes out
// as a one-cycle done_o strobe with res_o; results keep input order and the
// sink must take them as they appear. The pipe depth is that of the
// divide-by-constant chain of the Gregorian lane (alpha, year count, month
// index, each a reciprocal multiply followed by a register); the aligned-year
// lane (3 stages) feeds the year-fraction long division (4 stages) and
// matches it. No state is kept between beats.
module mjd_to_decimal_year_core
  import mjd2y_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  mjd2y_in_t  in_i,
  output logic       done_o,
  output mjd2y_res_t res_o
);

  localparam int unsigned PQ_W = JM1_W + MQ_W;
  localparam int unsigned QM_W = QUAD_W + REM_W;
  localparam int unsigned NY_W = QUAD_W + 2;

  logic acc;

  // aligned lane
  logic [ALGN_LAT-1:0]  a_vld_q;
  logic [JM1_W-1:0]     jm1, jm1_q;
  logic [PQ_W-1:0]      pq_q;
  logic [FRAC_BITS-1:0] frac1_q, frac2_q, frac3_q;
  logic [QUAD_W-1:0]    quad, quad_q;
  logic [QM_W-1:0]      q1461;
  logic [REM_W-1:0]     r0, r0_q;
  logic [1:0]           yq;
  logic [REM_W-1:0]     yq_off;
  logic [REM_W-1:0]     tw;
  logic [YDAY_W-1:0]    t;
  logic                 late;
  logic                 leap;
  logic [2:0]           yy;
  logic [YDAY_W-1:0]    nd_d, nd_q;
  logic [NY_W-1:0]      ny_w;
  logic [YEAR_W-1:0]    ny_d, ny_q;

  // matching delay for aligned fields
  logic [YEAR_W-1:0]    ny_dly_q [YF_LAT];
  logic [YDAY_W-1:0]    nd_dly_q [YF_LAT];

  logic                 greg_vld;
  logic [YEAR_W-1:0]    greg_year;
  logic [MONTH_W-1:0]   greg_month;
  logic [MDAY_W-1:0]    greg_day;
  logic                 yf_vld;
  logic [YFRAC_W-1:0]   yf;

  // Pure feed-forward pipe, nothing to hold off
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  mjd2y_greg u_greg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .mday_i  (in_i.mjd_day),
    .valid_o (greg_vld),
    .year_o  (greg_year),
    .month_o (greg_month),
    .day_o   (greg_day)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= '0;
    end else begin
      a_vld_q <= {a_vld_q[ALGN_LAT-2:0], acc};
    end
  end

  // a1: days since the aligned epoch, minus one. The Gregorian date maps back
  // to the same day number, so the aligned calendar runs straight off the MJD.
  assign jm1 = JM1_W'(in_i.mjd_day) + JM1_W'(JM1_OFS);

  // a2: split into four-year cycles; r0 is the day within the cycle, from 0
  always_comb begin
    quad  = pq_q[SQ +: QUAD_W];
    q1461 = QM_W'(quad) * QM_W'(YEAR_DIV);
    r0    = REM_W'(jm1_q - JM1_W'(q1461));
  end

  // a3: year in the cycle. Years run from March; the last day of the cycle
  // (r0 = 1460) stays in year three as its leap day.
  always_comb begin
    yq = 2'(r0_q >= REM_W'(365)) + 2'(r0_q >= REM_W'(730)) + 2'(r0_q >= REM_W'(1095));
    case (yq)
      2'd0:    yq_off = REM_W'(0);
      2'd1:    yq_off = REM_W'(365);
      2'd2:    yq_off = REM_W'(730);
      default: yq_off = REM_W'(1095);
    endcase
    tw   = r0_q + REM_W'(1) - yq_off;
    t    = YDAY_W'(tw);
    // January and February belong to the next calendar year
    late = (t >= YDAY_W'(307));
    // leap day lands in the first year of the cycle
    leap = (yq == 2'd0) && !late;
    yy   = 3'(yq) + 3'(late);
    nd_d = late ? (t - YDAY_W'(306)) : (t + YDAY_W'(59) + YDAY_W'(leap));
    ny_w = NY_W'({quad_q, 2'b00}) + NY_W'(yy) - NY_W'(YEAR_BASE);
    ny_d = ny_w[YEAR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      jm1_q   <= jm1;
      pq_q    <= PQ_W'(jm1) * PQ_W'(MQ);
      frac1_q <= in_i.mjd_frac;
    end
    if (a_vld_q[0]) begin
      quad_q  <= quad;
      r0_q    <= r0;
      frac2_q <= frac1_q;
    end
    if (a_vld_q[1]) begin
      nd_q    <= nd_d;
      ny_q    <= ny_d;
      frac3_q <= frac2_q;
    end
  end

  mjd2y_yfrac u_yfrac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_vld_q[ALGN_LAT-1]),
    .nd_i    (nd_q),
    .frac_i  (frac3_q),
    .valid_o (yf_vld),
    .yf_o    (yf)
  );

  // Free-running delay; the fraction lane has a fixed depth, so slots line up
  always_ff @(posedge clk_i) begin
    ny_dly_q[0] <= ny_q;
    nd_dly_q[0] <= nd_q;
    for (int i = 1; i < YF_LAT; i++) begin
      ny_dly_q[i] <= ny_dly_q[i-1];
      nd_dly_q[i] <= nd_dly_q[i-1];
    end
  end

  assign done_o = yf_vld;

  always_comb begin
    res_o.greg_year     = greg_year;
    res_o.greg_month    = greg_month;
    res_o.greg_day      = greg_day;
    res_o.aligned_year  = ny_dly_q[YF_LAT-1];
    res_o.day_of_year   = nd_dly_q[YF_LAT-1];
    res_o.year_fraction = yf;
  end

  // both lanes must deliver the same beat on the same edge
  assert property (@(posedge clk_i) disable iff (!rst_ni) greg_vld == yf_vld)
    else $error("date lane and fraction lane out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni) acc |-> ##PIPE_LAT done_o)
    else $error("accepted beat did not come out after the pipe latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(acc, PIPE_LAT))
    else $error("result strobe without a matching accepted beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.greg_month >= MONTH_W'(1)) && (res_o.greg_month <= MONTH_W'(12)) &&
               (res_o.greg_day >= MDAY_W'(1)) &&
               (res_o.day_of_year >= YDAY_W'(1)) && (res_o.day_of_year <= YDAY_W'(366)))
    else $error("calendar field out of range");

endmodule

// ===== dv/mjd_to_decimal_year_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the converter, predicts each result from the
// accepted beat and compares against the output in order.
module mjd_to_decimal_year_checker
  import mjd2y_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  mjd2y_in_t  in_i,
  input  logic       done_i,
  input  mjd2y_res_t res_i,
  output int         fail_count_o,
  output int         pending_o
);

  mjd2y_res_t due_dates_q[$];
  int         fails = 0;

  // Exact integer form of the date steps; every operand stays positive,
  // so truncating division equals floor division.
  function automatic mjd2y_res_t convert_mjd(mjd2y_in_t beat);
    longint jdn, alpha, b, c, d, e, g, mday, month, year;
    longint early, k, jda, quad, rem, yq, late, yy, ny, nd;
    logic [63:0] num, yf;
    mjd2y_res_t r;
    jdn   = longint'(beat.mjd_day) + 2400001;
    alpha = (4 * jdn - 7468865) / 146097;
    b     = jdn + 1 + alpha - alpha / 4;
    c     = b + 1524;
    d     = (20 * c - 2442) / 7305;
    e     = (1461 * d) / 4;
    g     = (10000 * (c - e)) / 306001;
    mday  = c - e - (306001 * g) / 10000;
    month = (g < 14) ? g - 1 : g - 13;
    year  = (month > 2) ? d - 4716 : d - 4715;
    // re-count the date in the aligned Julian calendar
    early = (14 - month) / 12;
    k     = year - early;
    jda   = (1461 * (k + 4800)) / 4 + (367 * (month - 2 + 12 * early)) / 12
          - (3 * ((k + 4900) / 100)) / 4 + mday - 30660;
    quad  = (jda - 1) / 1461;
    rem   = jda - 1461 * quad;
    yq    = (rem - 1) / 365 - rem / 1461;
    late  = ((80 * (rem - 365 * yq + 30)) / 2447) / 11;
    yy    = yq + late;
    nd    = 59 + rem - 365 * yy + ((4 - yq) / 4) * (1 - late);
    ny    = 4 * quad + yy - 4716;
    // (nd + frac) / 365.25 in Q1.32 == ((nd << 34) + frac scaled) / 1461
    num = nd;
    num = (num << FRAC_BITS) + beat.mjd_frac;
    if (FRAC_BITS <= 34) begin
      yf = (num << (34 - FRAC_BITS)) / 64'd1461;
    end else begin
      yf = num / (64'd1461 << (FRAC_BITS - 34));
    end
    r.greg_year     = year[YEAR_W-1:0];
    r.greg_month    = month[MONTH_W-1:0];
    r.greg_day      = mday[MDAY_W-1:0];
    r.aligned_year  = ny[YEAR_W-1:0];
    r.day_of_year   = nd[YDAY_W-1:0];
    r.year_fraction = yf[YFRAC_W-1:0];
    return r;
  endfunction

  function automatic string date_str(mjd2y_res_t r);
    return $sformatf("greg %0d-%0d-%0d aligned %0d day %0d frac %h",
                     r.greg_year, r.greg_month, r.greg_day,
                     r.aligned_year, r.day_of_year, r.year_fraction);
  endfunction

  always @(posedge clk_i) begin
    mjd2y_res_t want;
    if (rst_ni) begin
      // output side first: a result never belongs to the beat taken now
      if (done_i) begin
        if (due_dates_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: %s", date_str(res_i));
        end else begin
          want = due_dates_q.pop_front();
          if (res_i.greg_year     !== want.greg_year    ||
              res_i.greg_month    !== want.greg_month   ||
              res_i.greg_day      !== want.greg_day     ||
              res_i.aligned_year  !== want.aligned_year ||
              res_i.day_of_year   !== want.day_of_year  ||
              res_i.year_fraction !== want.year_fraction) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected %s", date_str(want));
              $display("          actual   %s", date_str(res_i));
            end
          end
        end
      end
      if (start_i && !busy_i) due_dates_q.push_back(convert_mjd(in_i));
      fail_count_o <= fails;
      pending_o    <= due_dates_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// Top of the converter bench: clock, reset, beat stimulus and the verdict.
// The checker beside the block does all prediction and comparison.
module testbench;
  import mjd2y_pkg::*;

  localparam int N_PHASES   = 4;
  localparam int PHASE_BEATS = 288;   // random beats per phase
  localparam int DRAIN_LIMIT = 2000;  // cycles allowed for the pipe to empty

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  mjd2y_in_t  in_i;
  logic       done_o;
  mjd2y_res_t res_o;
  int         fail_count;
  int         pending;

  // Sender idle chance, in percent, for the current phase.
  int         idle_pct;

  always #5 clk_i = ~clk_i;

  mjd_to_decimal_year_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  mjd_to_decimal_year_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (in_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Present one beat and hold it until an edge takes it. busy is read right
  // after the edge, before any NBA update, so it is the value that edge saw.
  task automatic send_beat(input mjd2y_in_t beat);
    start <= 1'b1;
    in_i  <= beat;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Idle cycles before a beat, drawn cycle by cycle at the phase's rate.
  // start is only lowered here, never in the same step as the next raise.
  task automatic maybe_idle();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // MJD of January 1st of Gregorian year yr (days-from-civil, shifted).
  function automatic int jan1_mjd(int yr);
    int yp;
    yp = yr - 1;
    return 365 * yp + yp / 4 - yp / 100 + yp / 400 - 678575;
  endfunction

  // Random beat: mostly uniform over the full fields, part of it clustered
  // around year starts, leap days and year ends, some with extreme fractions.
  function automatic mjd2y_in_t make_beat();
    mjd2y_in_t beat;
    int        offs[8] = '{-1, 0, 1, 58, 59, 60, 364, 365};
    int        pick;
    pick = $urandom_range(9);
    beat.mjd_day  = DAY_BITS'($urandom);
    beat.mjd_frac = FRAC_BITS'($urandom);
    if (pick >= 6 && pick <= 8) begin
      beat.mjd_day = DAY_BITS'(jan1_mjd(int'($urandom_range(2217, 1859)))
                               + offs[$urandom_range(7)]);
    end else if (pick == 9) begin
      case ($urandom_range(3))
        0: beat.mjd_frac = '0;
        1: beat.mjd_frac = '1;
        2: beat.mjd_frac = FRAC_BITS'(1);
        default: beat.mjd_frac = {1'b1, {(FRAC_BITS-1){1'b0}}};
      endcase
    end
    return beat;
  endfunction

  // Directed dates: field extremes, leap day of a 400-year year, the
  // Gregorian non-leap century (where the aligned calendar still has a
  // leap day), year ends and starts, and alternating bit patterns.
  int directed_days[] = '{
    0, 131071, 1, 131070,
    15078, 15079, 15020, 15019,    // 1900: Feb 28, Mar 1, Jan 1; 1899-12-31
    51543, 51544, 51603, 51604,    // 1999-12-31, 2000-01-01, Feb 29, Mar 1
    51909, 53064, 88127, 88128,    // 2000-12-31, 2004-02-29, 2100 Feb/Mar
    87381, 43690                   // 0x15555, 0x0aaaa
  };

  initial begin
    mjd2y_in_t beat;
    int        waited;
    start    = 1'b0;
    in_i     = '0;
    rst_ni   = 1'b0;
    idle_pct = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, fractions swept over their extremes and patterns
    foreach (directed_days[i]) begin
      beat.mjd_day = DAY_BITS'(directed_days[i]);
      case (i % 4)
        0: beat.mjd_frac = '0;
        1: beat.mjd_frac = '1;
        2: beat.mjd_frac = 32'h5555_5555;
        default: beat.mjd_frac = 32'haaaa_aaaa;
      endcase
      send_beat(beat);
    end

    // random phases: back to back, heavy sender idling, light idling, back
    // to back again; the sink cannot stall, so only the sender varies
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        1:       idle_pct = 77;
        2:       idle_pct = 12;
        default: idle_pct = 0;
      endcase
      repeat (PHASE_BEATS) begin
        maybe_idle();
        send_beat(make_beat());
      end
    end
    start <= 1'b0;

    // drain: wait for every due result, then longer than the pipe depth so a
    // stray late strobe is still seen
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== mjd_to_decimal_year_core.f =====
rtl/core/mjd2y_pkg.sv
rtl/core/mjd2y_greg.sv
rtl/core/mjd2y_yfrac.sv
rtl/core/mjd_to_decimal_year_core.sv
dv/mjd_to_decimal_year_checker.sv
dv/testbench.sv
